// ===== rtl/core/fbc_pkg.sv =====
// Shared constants for the Feistel block cipher unit: S-box table, register
// indexes, reset values and round count. No dependencies.
package fbc_pkg;

   typedef logic [3:0] sbox_row_type [16];
   typedef sbox_row_type sbox_type [8];

   localparam int unsigned HALF_W  = 32;
   localparam int unsigned BLOCK_W = 64;
   localparam int unsigned ROT_L   = 11;

   localparam logic [4:0] ROUND_LAST = 5'd31;

   // configuration register indexes
   localparam logic [2:0] CSR_KEY0  = 3'd0;
   localparam logic [2:0] CSR_KEY1  = 3'd1;
   localparam logic [2:0] CSR_KEY2  = 3'd2;
   localparam logic [2:0] CSR_KEY3  = 3'd3;
   localparam logic [2:0] CSR_IV    = 3'd4;
   localparam logic [2:0] CSR_DIR   = 3'd5;
   localparam logic [2:0] CSR_CHAIN = 3'd6;

   localparam logic [63:0] KEY0_RST = 64'h0000_ACEF_0000_BACE;
   localparam logic [63:0] KEY1_RST = 64'h0000_DBAC_0000_FDBA;
   localparam logic [63:0] KEY2_RST = 64'h0000_0123_0000_4567;
   localparam logic [63:0] KEY3_RST = 64'h0000_89AB_0000_CDEF;
   localparam logic [63:0] IV_RST   = 64'hAACC_BBDD_11FF_10EE;

   // row j serves nibble j of the sum (bits 4j+3..4j)
   localparam sbox_type SBOX = '{
      '{4'hC,4'hA,4'h9,4'h2,4'hD,4'h8,4'h0,4'hE,4'h6,4'hB,4'h1,4'hC,4'h7,4'hF,4'h5,4'h1},
      '{4'hE,4'hB,4'h4,4'hC,4'h6,4'hD,4'hF,4'hA,4'h2,4'h3,4'h8,4'h1,4'h0,4'h7,4'h5,4'h9},
      '{4'h5,4'h8,4'h1,4'hD,4'hA,4'h3,4'h4,4'h2,4'hE,4'hF,4'hC,4'h7,4'h6,4'h0,4'h9,4'hB},
      '{4'h7,4'hD,4'hA,4'h1,4'h0,4'h8,4'h9,4'hF,4'hE,4'h4,4'h6,4'hC,4'hB,4'h2,4'h5,4'h3},
      '{4'h6,4'hC,4'h7,4'h1,4'h5,4'hF,4'hD,4'h8,4'h4,4'hA,4'h9,4'hE,4'h0,4'h3,4'hB,4'h2},
      '{4'h4,4'hB,4'hA,4'h0,4'h7,4'h2,4'h1,4'hD,4'h3,4'h6,4'h8,4'h5,4'h9,4'hC,4'hF,4'hE},
      '{4'hD,4'hB,4'h4,4'h1,4'h3,4'hF,4'h5,4'h9,4'h0,4'hA,4'hE,4'h7,4'h6,4'h8,4'h2,4'hC},
      '{4'h3,4'hF,4'hD,4'h0,4'h5,4'h7,4'hA,4'h4,4'h9,4'h2,4'h3,4'hE,4'h6,4'hB,4'h8,4'h4}
   };

endpackage

// ===== rtl/core/fbc_round.sv =====
// One Feistel round: key add mod 2^32, S-box substitution, rotate, XOR.
// Depends on fbc_pkg for the S-box table.
module fbc_round
   import fbc_pkg::*;
(
   input  logic [HALF_W-1:0] left,
   input  logic [HALF_W-1:0] right,
   input  logic [HALF_W-1:0] subkey,
   output logic [HALF_W-1:0] new_right
);

   logic [HALF_W-1:0] sum;
   logic [HALF_W-1:0] sub;

   assign sum = right + subkey;

   always_comb begin
      for (int j = 0; j < 8; j++) begin
         sub[4*j +: 4] = SBOX[j][sum[4*j +: 4]];
      end
   end

   assign new_right = left ^ {sub[HALF_W-ROT_L-1:0], sub[HALF_W-1:HALF_W-ROT_L]};

endmodule

// ===== rtl/core/feistel_block_cipher_cbc_unit.sv =====
// Top level of the 64-bit Feistel block cipher with ECB/CBC chaining.
// Depends on fbc_pkg and fbc_round.
// Usage:
//   req_* carries one 64-bit block per transfer; req_tuser flags the first
//   block of a message, which reloads the chain block from the IV.
//   rsp_* returns one 64-bit block per request, in order.
//   csr_* writes the key pairs, IV, direction and chaining mode; write only
//   while no block is in flight.
// Timing:
//   A block goes from request transfer through the single round unit, one
//   round per cycle, to the finish state, which applies the chaining XOR
//   and loads the output register. One block is in the round unit at a
//   time and req_tready is high only while idle, so a new block is taken
//   only after the last result has been loaded into the output register.
// Stalls:
//   The finished result waits in the sequencer until the output register
//   is free, holding off the input; rsp_tdata holds while rsp_tready is low.
// Reset:
//   Keys, IV, encrypt and ECB settings return to their defaults, the chain
//   block clears to zero and both channels go idle.
module feistel_block_cipher_cbc_unit
   import fbc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] data_block
   input  logic        req_tuser,   // [0] message_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] result_block
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [4:0]  round_ff, round_in;
   logic [63:0] key_ff [4];
   logic [63:0] iv_ff;
   logic        dir_ff;
   logic        chain_en_ff;
   logic [63:0] chain_ff, chain_in;
   logic [63:0] data_ff;
   logic [31:0] left_ff, left_in;
   logic [31:0] right_ff, right_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff, rsp_data_in;

   logic        req_xfer;
   logic        out_free;
   logic [63:0] chain_eff;
   logic [63:0] feed;
   logic        fwd_order;
   logic [2:0]  key_sel;
   logic [63:0] key_pair;
   logic [31:0] subkey;
   logic [31:0] round_out;
   logic [63:0] final_blk;
   logic [63:0] result;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // chain restarts from the IV on the first block of a message
   assign chain_eff = req_tuser ? iv_ff : chain_ff;
   assign feed      = (chain_en_ff && !dir_ff) ? (req_tdata ^ chain_eff) : req_tdata;

   // encrypt: 0..7 for rounds 0..23, then 7..0; decrypt: 0..7 then 7..0 thrice
   assign fwd_order = dir_ff ? (round_ff[4:3] == 2'd0) : (round_ff[4:3] != 2'd3);
   assign key_sel   = fwd_order ? round_ff[2:0] : ~round_ff[2:0];
   assign key_pair  = key_ff[key_sel[2:1]];
   assign subkey    = key_sel[0] ? key_pair[31:0] : key_pair[63:32];

   fbc_round u_round (
      .left      (left_ff),
      .right     (right_ff),
      .subkey    (subkey),
      .new_right (round_out)
   );

   // halves already swapped after the last round
   assign final_blk = {right_ff, left_ff};
   assign result    = (chain_en_ff && dir_ff) ? (final_blk ^ chain_ff) : final_blk;

   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      chain_in     = chain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               chain_in = chain_eff;
               left_in  = feed[63:32];
               right_in = feed[31:0];
               round_in = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            left_in  = right_ff;
            right_in = round_out;
            round_in = round_ff + 5'd1;
            if (round_ff == ROUND_LAST) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // hold until the output register can take the result
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result;
               if (chain_en_ff) begin
                  chain_in = dir_ff ? data_ff : final_blk;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         chain_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
         chain_ff     <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff     <= left_in;
      right_ff    <= right_in;
      rsp_data_ff <= rsp_data_in;
      if (req_xfer) begin
         data_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff[0]   <= KEY0_RST;
         key_ff[1]   <= KEY1_RST;
         key_ff[2]   <= KEY2_RST;
         key_ff[3]   <= KEY3_RST;
         iv_ff       <= IV_RST;
         dir_ff      <= 1'b0;
         chain_en_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index) inside
            CSR_KEY0, CSR_KEY1, CSR_KEY2, CSR_KEY3: key_ff[csr_index[1:0]] <= csr_wdata;
            CSR_IV:    iv_ff       <= csr_wdata;
            CSR_DIR:   dir_ff      <= csr_wdata[0];
            CSR_CHAIN: chain_en_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_start_run: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == ST_RUN) && (round_ff == 5'd0))
      else $error("request transfer did not start the round sequence");

   a_last_round: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) && (round_ff == ROUND_LAST) |=> (state_ff == ST_FIN))
      else $error("sequencer did not finish after the last round");

   a_fin_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) && out_free |=> (state_ff == ST_IDLE) && rsp_valid_ff)
      else $error("finished block not loaded into the output register");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FIN))
      else $error("result raised without a finished block");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for feistel_block_cipher_cbc_unit: a directed table of blocks, then random
// messages over many key, IV and ECB/CBC settings, each result checked against a cipher model
// kept in the bench. Depends on fbc_pkg and the unit's RTL.
module testbench
   import fbc_pkg::*;
();

   localparam logic ENCRYPT  = 1'b0;
   localparam logic DECRYPT  = 1'b1;
   localparam logic MODE_ECB = 1'b0;
   localparam logic MODE_CBC = 1'b1;
   // index past the register list, writes to it must change nothing
   localparam logic [2:0] CSR_SPARE = 3'd7;

   localparam int PHASES           = 16;
   localparam int BLOCKS_PER_PHASE = 100;
   localparam int LONG_HOLD        = 400;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int SETTLE_CYCLES    = 40;
   localparam int REPORT_MAX       = 10;

   // row j substitutes nibble j of the round sum
   localparam logic [3:0] SUBST [8][16] = '{
      '{4'hC,4'hA,4'h9,4'h2,4'hD,4'h8,4'h0,4'hE,4'h6,4'hB,4'h1,4'hC,4'h7,4'hF,4'h5,4'h1},
      '{4'hE,4'hB,4'h4,4'hC,4'h6,4'hD,4'hF,4'hA,4'h2,4'h3,4'h8,4'h1,4'h0,4'h7,4'h5,4'h9},
      '{4'h5,4'h8,4'h1,4'hD,4'hA,4'h3,4'h4,4'h2,4'hE,4'hF,4'hC,4'h7,4'h6,4'h0,4'h9,4'hB},
      '{4'h7,4'hD,4'hA,4'h1,4'h0,4'h8,4'h9,4'hF,4'hE,4'h4,4'h6,4'hC,4'hB,4'h2,4'h5,4'h3},
      '{4'h6,4'hC,4'h7,4'h1,4'h5,4'hF,4'hD,4'h8,4'h4,4'hA,4'h9,4'hE,4'h0,4'h3,4'hB,4'h2},
      '{4'h4,4'hB,4'hA,4'h0,4'h7,4'h2,4'h1,4'hD,4'h3,4'h6,4'h8,4'h5,4'h9,4'hC,4'hF,4'hE},
      '{4'hD,4'hB,4'h4,4'h1,4'h3,4'hF,4'h5,4'h9,4'h0,4'hA,4'hE,4'h7,4'h6,4'h8,4'h2,4'hC},
      '{4'h3,4'hF,4'hD,4'h0,4'h5,4'h7,4'hA,4'h4,4'h9,4'h2,4'h3,4'hE,4'h6,4'hB,4'h8,4'h4}
   };

   typedef struct packed {
      logic        dir;
      logic        chain;
      logic        first;
      logic [63:0] data;
   } directed_block_type;

   // runs on the reset keys and IV; mode switches happen between rows
   localparam directed_block_type DIRECTED [16] = '{
      '{ENCRYPT, MODE_ECB, 1'b0, 64'h0000_0000_0000_0000},
      '{ENCRYPT, MODE_ECB, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF},
      '{ENCRYPT, MODE_ECB, 1'b0, 64'h0123_4567_89AB_CDEF},
      // CBC with no message start yet: chain begins at zero
      '{ENCRYPT, MODE_CBC, 1'b0, 64'h0000_0000_0000_0000},
      '{ENCRYPT, MODE_CBC, 1'b0, 64'hFEDC_BA98_7654_3210},
      '{ENCRYPT, MODE_CBC, 1'b1, 64'h0000_0000_0000_0000},
      '{ENCRYPT, MODE_CBC, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF},
      '{DECRYPT, MODE_CBC, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
      '{DECRYPT, MODE_CBC, 1'b0, 64'h0000_0000_0000_0000},
      '{DECRYPT, MODE_CBC, 1'b0, 64'h8000_0000_0000_0001},
      '{DECRYPT, MODE_ECB, 1'b0, 64'h0000_0000_0000_0000},
      '{DECRYPT, MODE_ECB, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF},
      // message start in ECB still reloads the chain from the IV
      '{DECRYPT, MODE_ECB, 1'b1, 64'h5555_AAAA_5555_AAAA},
      '{DECRYPT, MODE_CBC, 1'b0, 64'hAAAA_5555_AAAA_5555},
      '{ENCRYPT, MODE_ECB, 1'b1, 64'h0000_0000_0000_0000},
      '{ENCRYPT, MODE_CBC, 1'b0, 64'h0000_0000_0000_0001}
   };

   typedef enum {SINK_FREE, SINK_COIN, SINK_SPARSE, SINK_BEAT} sink_mode_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        csr_we     = 1'b0;
   logic [2:0]  csr_index  = CSR_KEY0;
   logic [63:0] csr_wdata  = '0;

   // cipher model state
   logic [63:0] key_pairs [4];
   logic [63:0] iv_model;
   logic        dir_model;
   logic        chain_mode_model;
   logic [63:0] chain_model;

   logic [63:0] pending_blocks [$];
   int unsigned blocks_sent    = 0;
   int unsigned blocks_checked = 0;
   int unsigned error_count    = 0;
   int unsigned holds_done     = 0;
   int unsigned burst_left     = 0;
   bit          hold_request   = 1'b0;

   always #4 clock = ~clock;

   feistel_block_cipher_cbc_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [63:0] data_block
      .req_tuser  (req_tuser),    // [0] message_start
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [63:0] result_block
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] random_block();
      case ($urandom_range(0, 15))
         0: return 64'h0000_0000_0000_0000;
         1: return 64'hFFFF_FFFF_FFFF_FFFF;
         default: return rand_word();
      endcase
   endfunction

   // add subkey, substitute nibbles, rotate left by 11
   function automatic logic [31:0] round_mix(input logic [31:0] half, input logic [31:0] k);
      logic [31:0] sum;
      logic [31:0] sub;
      sum = half + k;
      for (int j = 0; j < 8; j++)
         sub[4*j +: 4] = SUBST[j][sum[4*j +: 4]];
      return {sub[20:0], sub[31:21]};
   endfunction

   function automatic logic [63:0] feistel_pass(input logic [63:0] blk, input logic decrypt);
      logic [31:0] left;
      logic [31:0] right;
      logic [31:0] t;
      logic [31:0] k;
      int unsigned n;
      left  = blk[63:32];
      right = blk[31:0];
      for (int i = 0; i < 32; i++) begin
         if (decrypt == ENCRYPT)
            n = (i < 24) ? i % 8 : 31 - i;
         else
            n = (i < 8) ? i : 7 - i % 8;
         k = n[0] ? key_pairs[n >> 1][31:0] : key_pairs[n >> 1][63:32];
         t = left ^ round_mix(right, k);
         left  = right;
         right = t;
      end
      return {right, left};
   endfunction

   function automatic logic [63:0] next_cipher_block(input logic [63:0] data, input logic first);
      logic [63:0] res;
      if (first)
         chain_model = iv_model;
      if (chain_mode_model == MODE_ECB) begin
         res = feistel_pass(data, dir_model);
      end else if (dir_model == ENCRYPT) begin
         res = feistel_pass(data ^ chain_model, ENCRYPT);
         chain_model = res;
      end else begin
         res = feistel_pass(data, DECRYPT) ^ chain_model;
         chain_model = data;
      end
      return res;
   endfunction

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_KEY0, CSR_KEY1, CSR_KEY2, CSR_KEY3: key_pairs[idx[1:0]] = value;
         CSR_IV:    iv_model = value;
         CSR_DIR:   dir_model = value[0];
         CSR_CHAIN: chain_mode_model = value[0];
         default: ;
      endcase
   endtask

   task automatic send_block(input logic [63:0] blk, input logic first);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= blk;
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
      pending_blocks.insert(pending_blocks.size(), next_cipher_block(blk, first));
      blocks_sent++;
   endtask

   // hold the input idle until every outstanding block has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_blocks.size() != 0) @(posedge clock);
   endtask

   task automatic program_phase(input int phase);
      logic [63:0] junk;
      logic        dir_bit;
      logic        chain_bit;
      for (int r = 0; r < 4; r++)
         write_reg(CSR_KEY0 + 3'(r), phase == 0 ? 64'h0 : phase == 1 ? '1 : rand_word());
      write_reg(CSR_IV, phase == 0 ? 64'h0 : phase == 1 ? '1 : rand_word());
      dir_bit   = (phase < 4) ? phase[0] : 1'($urandom_range(0, 1));
      chain_bit = (phase < 4) ? phase[1] : 1'($urandom_range(0, 1));
      // only bit 0 of the one-bit registers counts; fill the rest with noise
      junk = rand_word();
      write_reg(CSR_DIR, {junk[63:1], dir_bit});
      junk = rand_word();
      write_reg(CSR_CHAIN, {junk[63:1], chain_bit});
      write_reg(CSR_SPARE, rand_word());
   endtask

   initial begin : stimulus
      directed_block_type row;
      logic [63:0]        junk;
      int unsigned        msg_len;
      int unsigned        phase_blocks;
      key_pairs[0]     = 64'h0000_ACEF_0000_BACE;
      key_pairs[1]     = 64'h0000_DBAC_0000_FDBA;
      key_pairs[2]     = 64'h0000_0123_0000_4567;
      key_pairs[3]     = 64'h0000_89AB_0000_CDEF;
      iv_model         = 64'hAACC_BBDD_11FF_10EE;
      dir_model        = ENCRYPT;
      chain_mode_model = MODE_ECB;
      chain_model      = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < 16; r++) begin
         row = DIRECTED[r];
         if (row.dir != dir_model || row.chain != chain_mode_model) begin
            drain();
            junk = rand_word();
            write_reg(CSR_DIR, {junk[63:1], row.dir});
            write_reg(CSR_CHAIN, {junk[63:1], row.chain});
         end
         send_block(row.data, row.first);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         program_phase(phase);
         if (phase == 3 || phase == 11)
            hold_request = 1'b1;
         phase_blocks = 0;
         while (phase_blocks < BLOCKS_PER_PHASE) begin
            if ($urandom_range(0, 7) == 0) begin
               // stray block with a random start flag
               send_block(random_block(), 1'($urandom_range(0, 1)));
               phase_blocks++;
            end else begin
               msg_len = $urandom_range(1, 12);
               for (int b = 0; b < msg_len; b++)
                  send_block(random_block(), b == 0);
               phase_blocks += msg_len;
            end
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      error_count += pending_blocks.size();
      $display("ran %0d blocks over %0d key, IV and mode settings with %0d long output stalls;",
               blocks_sent, PHASES + 1, holds_done);
      $display("%0d results checked, %0d failures", blocks_checked, error_count);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin : result_sink
      logic [63:0]   want;
      sink_mode_type mode;
      int unsigned   mode_left;
      int unsigned   hold_left;
      int unsigned   beat;
      mode      = SINK_FREE;
      mode_left = 0;
      hold_left = 0;
      beat      = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready && !reset) begin
            if (pending_blocks.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_MAX)
                  $display("unexpected result %h with nothing outstanding", rsp_tdata);
            end else begin
               want = pending_blocks.pop_front();
               if (rsp_tdata !== want) begin
                  error_count++;
                  if (error_count <= REPORT_MAX)
                     $display("result %0d: expected %h, got %h", blocks_checked, want, rsp_tdata);
               end
               blocks_checked++;
            end
         end
         beat++;
         if (hold_left != 0) begin
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD;
            holds_done++;
         end
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = sink_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            case (mode)
               SINK_FREE:   rsp_tready <= 1'b1;
               SINK_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
               SINK_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
               default:     rsp_tready <= (beat % 7) < 4;
            endcase
         end
      end
   end

   initial begin : watchdog
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

endmodule
